>>> design/gauss_seidel_grid_solver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid solver
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef GAUSS_SEIDEL_GRID_SOLVER_ASSERT_SVH
`define GAUSS_SEIDEL_GRID_SOLVER_ASSERT_SVH

`ifndef ASSERT_OFF
// expression holds at every clock edge outside reset
`define GSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define GSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define GSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define GSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Types and constants shared by the grid solver modules.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int GRID_MAX   = 64;
    localparam int COORD_BITS = $clog2(GRID_MAX);
    localparam int ADDR_BITS  = 2 * COORD_BITS;
    localparam int CELLS      = GRID_MAX * GRID_MAX;
    localparam int VALUE_BITS = 32;
    localparam int SIZE_BITS  = 7;
    localparam int TOL_BITS   = 31;
    localparam int SWEEP_BITS = 16;
    localparam int Q_DEPTH    = 2;

    // request ops
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_GRID_SIZE  = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd1;
    localparam logic [1:0] CFG_MAX_SWEEPS = 2'd2;

    typedef struct packed {
        logic [1:0]                   op;
        logic [COORD_BITS-1:0]        row;
        logic [COORD_BITS-1:0]        col;
        logic signed [VALUE_BITS-1:0] cell_value;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_value;
        logic [SWEEP_BITS-1:0]        sweep_count;
        logic [TOL_BITS-1:0]          final_delta;
        logic                         converged;
    } t_out_rsp;

    typedef struct packed {
        logic [SIZE_BITS-1:0]  grid_size;
        logic [TOL_BITS-1:0]   tolerance;
        logic [SWEEP_BITS-1:0] max_sweeps;
    } t_cfg;

    // front queue status
    typedef struct packed {
        logic       push;
        logic       q_valid;
        logic [1:0] count;
    } t_front_stat;

    // back status
    typedef struct packed {
        logic pop;
        logic running;
    } t_back_stat;

endpackage

>>> design/gauss_seidel_grid_solver.sv
// ----------------------------------------------------------------------------
// gauss_seidel_grid_solver
// Laplace solver on a square Q16.16 grid by in-place Gauss-Seidel sweeps.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed one at a time from a
// single-port-write grid RAM. A run updates each interior cell by five stencil
// reads through the one RAM read port, an average and a write back, and sweeps
// the interior until it converges or the sweep limit is reached. Results wait
// in an output register while the queue keeps taking requests until it is
// full. No clearing pass follows reset.
module gauss_seidel_grid_solver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  gss_pkg::t_in_req           i_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output gss_pkg::t_out_rsp          o_rsp,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [gss_pkg::TOL_BITS-1:0] i_cfg_data
);

`include "gauss_seidel_grid_solver_assert.svh"

    gss_pkg::t_cfg       r_cfg;
    gss_pkg::t_in_req    q_req;
    gss_pkg::t_front_stat f_stat;
    gss_pkg::t_back_stat  b_stat;
    logic                q_valid, pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_size  <= 7'd64;
            r_cfg.tolerance  <= 31'd655360;
            r_cfg.max_sweeps <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gss_pkg::CFG_GRID_SIZE:  r_cfg.grid_size  <= i_cfg_data[6:0];
                gss_pkg::CFG_TOLERANCE:  r_cfg.tolerance  <= i_cfg_data;
                gss_pkg::CFG_MAX_SWEEPS: r_cfg.max_sweeps <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    gss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_req    (i_req),
        .i_pop    (pop),
        .o_q_valid(q_valid),
        .o_q_req  (q_req),
        .o_stat   (f_stat)
    );

    gss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_valid(q_valid),
        .i_q_req  (q_req),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_rsp    (o_rsp),
        .o_stat   (b_stat)
    );

    // checks
    `GSS_ASSERT_IMPL(a_run_out_empty, i_clk, i_rst_n, b_stat.running, !o_valid)
    `GSS_ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, f_stat.count <= 2'd2)
    `GSS_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, b_stat.pop, f_stat.q_valid)
    `GSS_ASSERT_IMPL(a_run_no_pop, i_clk, i_rst_n, b_stat.running, !b_stat.pop)

endmodule

>>> design/gss_ram.sv
// ----------------------------------------------------------------------------
// gss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/gss_front.sv
// ----------------------------------------------------------------------------
// gss_front
// Accepts requests, drops unknown ops and queues the rest for the back end.
// ----------------------------------------------------------------------------
module gss_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  gss_pkg::t_in_req     i_req,
    input  logic                 i_pop,
    output logic                 o_q_valid,
    output gss_pkg::t_in_req     o_q_req,
    output gss_pkg::t_front_stat o_stat
);

    gss_pkg::t_in_req r_q [gss_pkg::Q_DEPTH];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_count, n_count;
    logic             push, pop;

    assign o_ready = (r_count != 2'(gss_pkg::Q_DEPTH));
    // unknown op never enters the queue
    assign push    = i_valid && o_ready && (i_req.op != gss_pkg::OP_NONE);
    assign pop     = i_pop && (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= i_req;
        end
    end

    assign o_q_valid      = (r_count != 2'd0);
    assign o_q_req        = r_q[r_rptr];
    assign o_stat.push    = push;
    assign o_stat.q_valid = o_q_valid;
    assign o_stat.count   = r_count;

endmodule

>>> design/gss_back.sv
// ----------------------------------------------------------------------------
// gss_back
// Executes queued requests: cell writes, cell reads and Gauss-Seidel runs.
// ----------------------------------------------------------------------------
module gss_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gss_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  gss_pkg::t_in_req    i_q_req,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output gss_pkg::t_out_rsp   o_rsp,
    output gss_pkg::t_back_stat o_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    localparam int CB = gss_pkg::COORD_BITS;
    localparam int VB = gss_pkg::VALUE_BITS;
    localparam int SB = VB + 2;   // four-term sum
    localparam int DB = VB + 1;   // absolute change

    logic [1:0]                  r_state;
    logic [2:0]                  r_phase;
    logic [CB-1:0]               r_i, r_j;
    logic signed [SB-1:0]        r_sum;
    logic signed [VB-1:0]        r_nv, r_old;
    logic [DB-1:0]               r_worst;
    logic [gss_pkg::SWEEP_BITS-1:0] r_count;
    logic                        r_out_valid;
    gss_pkg::t_out_rsp           r_out;

    logic                        ram_we;
    logic [gss_pkg::ADDR_BITS-1:0] ram_waddr, ram_raddr;
    logic [VB-1:0]               ram_wdata, ram_rdata;

    logic [gss_pkg::SIZE_BITS-1:0]  last7;
    logic [CB-1:0]                  last;
    logic [gss_pkg::SWEEP_BITS-1:0] limit, cnt_next;
    logic signed [SB-1:0]           rd_ext, diff;
    logic [DB-1:0]                  abs_d, new_worst;
    logic                           can_take, last_cell;

    // clamped interior bound and sweep limit
    always_comb begin
        if (i_cfg.grid_size < 7'd3) begin
            last7 = 7'd1;
        end else if (i_cfg.grid_size > 7'(gss_pkg::GRID_MAX)) begin
            last7 = 7'(gss_pkg::GRID_MAX - 2);
        end else begin
            last7 = i_cfg.grid_size - 7'd2;
        end
    end
    assign last  = last7[CB-1:0];
    assign limit = (i_cfg.max_sweeps == '0) ? 16'd1 : i_cfg.max_sweeps;

    // queue pop: writes need no output slot
    assign can_take = (i_q_req.op == gss_pkg::OP_WRITE) || !r_out_valid;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid && can_take;

    // stencil read address per phase: N, S, E, W, center
    always_comb begin
        ram_raddr = {i_q_req.row, i_q_req.col};
        if (r_state == ST_RUN) begin
            case (r_phase)
                3'd0:    ram_raddr = {r_i - CB'(1), r_j};
                3'd1:    ram_raddr = {r_i + CB'(1), r_j};
                3'd2:    ram_raddr = {r_i, r_j + CB'(1)};
                3'd3:    ram_raddr = {r_i, r_j - CB'(1)};
                default: ram_raddr = {r_i, r_j};
            endcase
        end
    end

    // write port: loaded cells or updated stencil cell
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_i, r_j};
        ram_wdata = r_nv;
        if (r_state == ST_IDLE) begin
            ram_we    = o_pop && (i_q_req.op == gss_pkg::OP_WRITE);
            ram_waddr = {i_q_req.row, i_q_req.col};
            ram_wdata = i_q_req.cell_value;
        end else if (r_state == ST_RUN && r_phase == 3'd6) begin
            ram_we = 1'b1;
        end
    end

    gss_ram #(.WIDTH(VB), .DEPTH(gss_pkg::CELLS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // change of the current cell and running maximum
    assign rd_ext    = SB'(signed'(ram_rdata));
    assign diff      = SB'(r_nv) - SB'(r_old);
    assign abs_d     = diff[SB-1] ? DB'(-diff) : DB'(diff);
    assign new_worst = (abs_d > r_worst) ? abs_d : r_worst;
    assign last_cell = (r_i == last) && (r_j == last);
    assign cnt_next  = r_count + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop && i_q_req.op == gss_pkg::OP_READ) begin
                        r_state <= ST_RD;
                    end else if (o_pop && i_q_req.op == gss_pkg::OP_RUN) begin
                        r_state <= ST_RUN;
                        r_phase <= 3'd0;
                    end
                end
                ST_RD: begin
                    r_state     <= ST_IDLE;
                    r_out_valid <= 1'b1;
                end
                ST_RUN: begin
                    if (r_phase == 3'd6) begin
                        r_phase <= 3'd0;
                        if (last_cell && (new_worst <= DB'(i_cfg.tolerance)
                                          || cnt_next >= limit)) begin
                            r_state     <= ST_IDLE;
                            r_out_valid <= 1'b1;
                        end
                    end else begin
                        r_phase <= r_phase + 3'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && o_pop) begin
            r_i     <= CB'(1);
            r_j     <= CB'(1);
            r_worst <= '0;
            r_count <= '0;
        end
        if (r_state == ST_RD) begin
            r_out.read_value  <= ram_rdata;
            r_out.sweep_count <= '0;
            r_out.final_delta <= '0;
            r_out.converged   <= 1'b0;
        end
        if (r_state == ST_RUN) begin
            case (r_phase)
                3'd1:    r_sum <= rd_ext;
                3'd2,
                3'd3,
                3'd4:    r_sum <= r_sum + rd_ext;
                3'd5: begin
                    r_nv  <= VB'(r_sum >>> 2);
                    r_old <= ram_rdata;
                end
                3'd6: begin
                    if (r_j == last) begin
                        r_j <= CB'(1);
                        r_i <= last_cell ? CB'(1) : r_i + CB'(1);
                    end else begin
                        r_j <= r_j + CB'(1);
                    end
                    if (last_cell) begin
                        r_count <= cnt_next;
                        r_worst <= '0;
                        r_out.read_value  <= '0;
                        r_out.sweep_count <= cnt_next;
                        r_out.final_delta <= new_worst[DB-1:gss_pkg::TOL_BITS] != '0
                                             ? '1 : new_worst[gss_pkg::TOL_BITS-1:0];
                        r_out.converged   <= (new_worst <= DB'(i_cfg.tolerance));
                    end else begin
                        r_worst <= new_worst;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rsp          = r_out;
    assign o_stat.pop     = o_pop;
    assign o_stat.running = (r_state == ST_RUN);

endmodule

>>> sim/tb_gauss_seidel_grid_solver.sv
// ----------------------------------------------------------------------------
// tb_gauss_seidel_grid_solver
// Self-checking bench for the Gauss-Seidel grid solver. Loads grids, reads
// cells back and runs solves under several register settings. A software
// copy of the grid predicts every response, which is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gauss_seidel_grid_solver;

    localparam int  LIMIT_CYCLES = 20000000;
    localparam longint DELTA_SAT = 64'h7FFF_FFFF;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    gss_pkg::t_in_req             i_req;
    logic                         o_valid;
    logic                         i_ready;
    gss_pkg::t_out_rsp            o_rsp;
    logic                         i_cfg_we;
    logic [1:0]                   i_cfg_idx;
    logic [gss_pkg::TOL_BITS-1:0] i_cfg_data;

    // shadow grid and register copy
    longint              grid_mem [gss_pkg::CELLS];
    int unsigned         sh_size;
    longint              sh_tol;
    int unsigned         sh_sweeps;

    gss_pkg::t_out_rsp   exp_rsp_q [$];
    int                  err_cnt;
    int                  cycle_cnt;
    bit                  no_idle;
    bit                  hold_go;
    bit                  hold_seen;
    int                  hold_cnt;
    int                  stall_left;

    gauss_seidel_grid_solver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // response side: random stalls, one long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cnt  <= 300;
            i_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            if (hold_cnt == 1)
                i_ready <= 1'b1;
        end else if (i_ready && o_valid) begin
            int s;
            s = no_idle ? 0 : $urandom_range(0, 6);
            stall_left <= s;
            if (s > 0)
                i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            gss_pkg::t_out_rsp e;
            if (exp_rsp_q.size() == 0) begin
                $display("unexpected response");
                err_cnt++;
            end else begin
                e = exp_rsp_q.pop_front();
                if (o_rsp.read_value !== e.read_value)
                    report_mismatch("read_value", o_rsp.read_value, e.read_value);
                if (o_rsp.sweep_count !== e.sweep_count)
                    report_mismatch("sweep_count", o_rsp.sweep_count, e.sweep_count);
                if (o_rsp.final_delta !== e.final_delta)
                    report_mismatch("final_delta", o_rsp.final_delta, e.final_delta);
                if (o_rsp.converged !== e.converged)
                    report_mismatch("converged", o_rsp.converged, e.converged);
            end
        end
    end

    // one in-place sweep over the interior, returns the largest change
    function automatic longint sweep_grid(input int unsigned n);
        longint worst, s, nv, d;
        int k;
        worst = 0;
        for (int i = 1; i < n - 1; i++) begin
            for (int j = 1; j < n - 1; j++) begin
                k  = i * gss_pkg::GRID_MAX + j;
                s  = grid_mem[k+1] + grid_mem[k-1] + grid_mem[k+gss_pkg::GRID_MAX]
                     + grid_mem[k-gss_pkg::GRID_MAX];
                nv = s >>> 2;
                d  = (nv >= grid_mem[k]) ? nv - grid_mem[k] : grid_mem[k] - nv;
                grid_mem[k] = nv;
                if (d > worst)
                    worst = d;
            end
        end
        return worst;
    endfunction

    // apply an accepted request to the shadow grid, queue its response
    task automatic predict_request(input gss_pkg::t_in_req r);
        gss_pkg::t_out_rsp rsp;
        int                k;
        int unsigned       n, lim, cnt;
        longint            delta;
        rsp = '0;
        k   = int'(r.row) * gss_pkg::GRID_MAX + int'(r.col);
        case (r.op)
            gss_pkg::OP_WRITE: begin
                grid_mem[k] = longint'($signed(r.cell_value));
            end
            gss_pkg::OP_READ: begin
                rsp.read_value = grid_mem[k][gss_pkg::VALUE_BITS-1:0];
                exp_rsp_q.push_back(rsp);
            end
            gss_pkg::OP_RUN: begin
                n   = (sh_size < 3) ? 3 : (sh_size > gss_pkg::GRID_MAX) ? gss_pkg::GRID_MAX
                                                                         : sh_size;
                lim = (sh_sweeps == 0) ? 1 : sh_sweeps;
                cnt = 0;
                forever begin
                    delta = sweep_grid(n);
                    cnt++;
                    if (delta <= sh_tol) begin
                        rsp.converged = 1'b1;
                        break;
                    end
                    if (cnt >= lim)
                        break;
                end
                rsp.sweep_count = cnt[gss_pkg::SWEEP_BITS-1:0];
                rsp.final_delta = (delta > DELTA_SAT) ? DELTA_SAT[gss_pkg::TOL_BITS-1:0]
                                                      : delta[gss_pkg::TOL_BITS-1:0];
                exp_rsp_q.push_back(rsp);
            end
            default: ;
        endcase
    endtask

    // send one request; valid stays up when the next one follows at once
    task automatic send_req(input logic [1:0] op, input int row, input int col,
                            input logic [31:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_req.op         <= op;
        i_req.row        <= row[gss_pkg::COORD_BITS-1:0];
        i_req.col        <= col[gss_pkg::COORD_BITS-1:0];
        i_req.cell_value <= val;
        do @(posedge i_clk); while (!o_ready);
        predict_request(i_req);
    endtask

    // wait until all responses are back and the back end is quiet
    task automatic drain;
        i_valid <= 1'b0;
        while (exp_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input longint val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[gss_pkg::TOL_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gss_pkg::CFG_GRID_SIZE:  sh_size   = 32'(val & 64'h7F);
            gss_pkg::CFG_TOLERANCE:  sh_tol    = val & 64'h7FFF_FFFF;
            gss_pkg::CFG_MAX_SWEEPS: sh_sweeps = 32'(val & 64'hFFFF);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value(input bit smooth);
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            default: return smooth ? 32'($signed($urandom_range(0, 131072)) - 65536)
                                   : $urandom;
        endcase
    endfunction

    // write every cell of an n x n grid
    task automatic load_grid(input int n, input bit smooth);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                send_req(gss_pkg::OP_WRITE, i, j, rand_value(smooth));
    endtask

    // extremes, read-back, ignored op, clamped size, sweep limit zero
    task automatic test_directed;
        write_cfg(gss_pkg::CFG_GRID_SIZE, 0);
        write_cfg(gss_pkg::CFG_TOLERANCE, 0);
        write_cfg(gss_pkg::CFG_MAX_SWEEPS, 0);
        // constant grid: no change, converges on the first sweep at zero tolerance
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                send_req(gss_pkg::OP_WRITE, i, j, 32'h0001_0000);
        send_req(gss_pkg::OP_RUN, 0, 0, 32'h0);
        send_req(gss_pkg::OP_NONE, 63, 63, 32'hFFFF_FFFF);
        send_req(gss_pkg::OP_WRITE, 63, 63, 32'h8000_0000);
        send_req(gss_pkg::OP_READ, 63, 63, 32'h0);
        send_req(gss_pkg::OP_WRITE, 1, 1, 32'h8000_0000);
        for (int j = 0; j < 3; j++) begin
            send_req(gss_pkg::OP_WRITE, 0, j, 32'h7FFF_FFFF);
            send_req(gss_pkg::OP_WRITE, 2, j, 32'h7FFF_FFFF);
        end
        send_req(gss_pkg::OP_WRITE, 1, 0, 32'h7FFF_FFFF);
        send_req(gss_pkg::OP_WRITE, 1, 2, 32'h7FFF_FFFF);
        drain;
        // huge change above a maximal tolerance: saturated delta, sweep limit
        write_cfg(gss_pkg::CFG_GRID_SIZE, 2);
        write_cfg(gss_pkg::CFG_TOLERANCE, 64'h7FFF_FFFF);
        write_cfg(gss_pkg::CFG_MAX_SWEEPS, 1);
        send_req(gss_pkg::OP_RUN, 0, 0, 32'h0);
        send_req(gss_pkg::OP_READ, 1, 1, 32'h0);
        drain;
    endtask

    // random phases on small grids
    task automatic test_random(input int phases);
        int n, kind, r, c;
        bit smooth;
        for (int p = 0; p < phases; p++) begin
            n      = $urandom_range(3, 6);
            smooth = $urandom_range(0, 1);
            no_idle = ($urandom_range(0, 3) == 0);
            write_cfg(gss_pkg::CFG_GRID_SIZE, n);
            case ($urandom_range(0, 3))
                0:       write_cfg(gss_pkg::CFG_TOLERANCE, 1);
                1:       write_cfg(gss_pkg::CFG_TOLERANCE, 64'h7FFF_FFFF);
                default: write_cfg(gss_pkg::CFG_TOLERANCE, $urandom_range(1, 2000000));
            endcase
            write_cfg(gss_pkg::CFG_MAX_SWEEPS, ($urandom_range(0, 4) == 0)
                                               ? 65535 : $urandom_range(1, 12));
            load_grid(n, smooth);
            for (int k = 0; k < 14; k++) begin
                kind = $urandom_range(0, 9);
                r    = $urandom_range(0, n - 1);
                c    = $urandom_range(0, n - 1);
                if (kind < 3) begin
                    if ($urandom_range(0, 2) == 0) begin
                        r = $urandom_range(0, 63);
                        c = $urandom_range(0, 63);
                    end
                    send_req(gss_pkg::OP_WRITE, r, c, rand_value(smooth));
                end else if (kind < 7) begin
                    send_req(gss_pkg::OP_READ, r, c, $urandom);
                end else if (kind < 9) begin
                    send_req(gss_pkg::OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom);
                end else begin
                    send_req(gss_pkg::OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom);
                end
            end
            drain;
        end
        no_idle = 1'b0;
    endtask

    // hold the response side off while requests keep coming
    task automatic test_backpressure;
        write_cfg(gss_pkg::CFG_GRID_SIZE, 4);
        load_grid(4, 1'b1);
        hold_go <= 1'b1;
        for (int k = 0; k < 12; k++)
            send_req(gss_pkg::OP_READ, $urandom_range(0, 3), $urandom_range(0, 3), 32'h0);
        send_req(gss_pkg::OP_RUN, 0, 0, 32'h0);
        drain;
    endtask

    // larger grid with full-range values, single sweep
    task automatic test_large_grid;
        write_cfg(gss_pkg::CFG_GRID_SIZE, 12);
        write_cfg(gss_pkg::CFG_TOLERANCE, 1);
        write_cfg(gss_pkg::CFG_MAX_SWEEPS, 1);
        no_idle = 1'b1;
        load_grid(12, 1'b0);
        no_idle = 1'b0;
        send_req(gss_pkg::OP_RUN, 0, 0, 32'h0);
        send_req(gss_pkg::OP_READ, 10, 10, 32'h0);
        send_req(gss_pkg::OP_READ, 11, 0, 32'h0);
        drain;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = gss_pkg::CFG_GRID_SIZE;
        i_cfg_data = '0;
        i_ready    = 1'b0;
        err_cnt    = 0;
        cycle_cnt  = 0;
        no_idle    = 1'b0;
        hold_go    = 1'b0;
        hold_seen  = 1'b0;
        hold_cnt   = 0;
        stall_left = 0;
        sh_size    = 64;
        sh_tol     = 655360;
        sh_sweeps  = 65535;
        for (int k = 0; k < gss_pkg::CELLS; k++)
            grid_mem[k] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed;
        test_random(16);
        test_backpressure;
        test_large_grid;

        drain;
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/gss_pkg.sv
design/gss_ram.sv
design/gss_front.sv
design/gss_back.sv
design/gauss_seidel_grid_solver.sv
sim/tb_gauss_seidel_grid_solver.sv
